/* rtl/efrc_pkg.sv */
// Package for the elevator FIFO request controller.
// Holds the payload structs, item kind and status codes, register indexes and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package efrc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERGROUND_COUNT = 2'd1;

  localparam logic [7:0] FLOOR_COUNT_RESET = 8'd10;
  localparam logic [6:0] UNDERGROUND_COUNT_RESET = 7'd2;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_TOGGLE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] requested_floor;
  } cmd_t;

  typedef struct packed {
    logic signed [7:0] car_level;
    logic              in_service;
    logic [15:0]       idle_ticks;
    logic [4:0]        queue_count;
    logic              served_now;
    logic [1:0]        status;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_ctrl_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

endpackage

/* rtl/efrc_ctrl.sv */
// Controller state machine for the elevator FIFO request controller.
// Sequences load and execute of one transaction; depends on efrc_pkg.
`timescale 1ns / 1ps

module efrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output efrc_pkg::dp_ctrl_t dp_ctrl
);
  import efrc_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  always_comb begin
    state_next   = state;
    busy         = 1'b0;
    dp_ctrl.load = 1'b0;
    dp_ctrl.exec = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          dp_ctrl.load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        busy         = 1'b1;
        dp_ctrl.exec = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/efrc_dpath.sv */
// Datapath for the elevator FIFO request controller: config registers, car state,
// shift-line request queue with per-cell duplicate compare, result register.
// Depends on efrc_pkg.
`timescale 1ns / 1ps

module efrc_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  efrc_pkg::dp_ctrl_t               dp_ctrl,
  input  efrc_pkg::cmd_t                   cmd,
  input  logic                             wr_en,
  input  logic [efrc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [efrc_pkg::CFG_DATA_W-1:0]  wr_data,
  output efrc_pkg::result_t                result
);
  import efrc_pkg::*;

  logic [7:0]        floor_count;
  logic [6:0]        underground_count;

  logic [1:0]        op_kind;
  logic signed [7:0] op_floor;

  logic signed [7:0] car_floor, car_floor_next;
  logic              service_flag, service_flag_next;
  logic [15:0]       idle_counter, idle_counter_next;
  logic [CNT_W-1:0]  pending_count, pending_count_next;
  logic signed [7:0] request_queue [QUEUE_DEPTH];

  logic              push, pop, served;
  status_t           status;
  logic              dup_hit;
  logic signed [9:0] top, bottom, fl_ext;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_count       <= FLOOR_COUNT_RESET;
      underground_count <= UNDERGROUND_COUNT_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_FLOOR_COUNT) floor_count <= wr_data;
      else if (wr_index == REG_UNDERGROUND_COUNT) underground_count <= wr_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.load) begin
      op_kind  <= cmd.kind;
      op_floor <= cmd.requested_floor;
    end
  end

  // Range bounds; floor_count can exceed 127 so work in 10 bits
  assign top    = $signed({2'b00, floor_count}) - 10'sd1 - $signed({3'b000, underground_count});
  assign bottom = -$signed({3'b000, underground_count});
  assign fl_ext = 10'(op_floor);

  always_comb begin
    dup_hit = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((CNT_W'(i) < pending_count) && (request_queue[i] == op_floor)) dup_hit = 1'b1;
    end
  end

  always_comb begin
    car_floor_next     = car_floor;
    service_flag_next  = service_flag;
    idle_counter_next  = idle_counter;
    pending_count_next = pending_count;
    push   = 1'b0;
    pop    = 1'b0;
    served = 1'b0;
    status = ST_OK;
    case (op_kind)
      KIND_TICK: begin
        if (idle_counter != IDLE_MAX) idle_counter_next = idle_counter + 16'd1;
        if (!service_flag && (pending_count != '0)) begin
          if (car_floor == request_queue[0]) begin
            idle_counter_next  = '0;
            pop                = 1'b1;
            pending_count_next = pending_count - CNT_W'(1);
            served             = 1'b1;
          end else if (car_floor < request_queue[0]) begin
            car_floor_next = car_floor + 8'sd1;
          end else begin
            car_floor_next = car_floor - 8'sd1;
          end
        end
      end
      KIND_REQUEST: begin
        if ((fl_ext > top) || (fl_ext < bottom)) status = ST_RANGE;
        else if (dup_hit) status = ST_DUPLICATE;
        else if (pending_count >= CNT_W'(QUEUE_DEPTH)) status = ST_FULL;
        else begin
          push               = 1'b1;
          pending_count_next = pending_count + CNT_W'(1);
        end
      end
      KIND_TOGGLE: begin
        if (service_flag) service_flag_next = 1'b0;
        else begin
          service_flag_next  = 1'b1;
          pending_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car_floor     <= '0;
      service_flag  <= 1'b0;
      idle_counter  <= '0;
      pending_count <= '0;
    end else if (dp_ctrl.exec) begin
      car_floor     <= car_floor_next;
      service_flag  <= service_flag_next;
      idle_counter  <= idle_counter_next;
      pending_count <= pending_count_next;
    end
  end

  // Queue cells: head at index 0, pop shifts every cell but the last down one
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (dp_ctrl.exec && push && (pending_count[IDX_W-1:0] == IDX_W'(i))) begin
        request_queue[i] <= op_floor;
      end else if (dp_ctrl.exec && pop && (i < QUEUE_DEPTH - 1)) begin
        request_queue[i] <= request_queue[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.exec) begin
      result.car_level     <= car_floor_next;
      result.in_service    <= service_flag_next;
      result.idle_ticks    <= idle_counter_next;
      result.queue_count   <= 5'(pending_count_next);
      result.served_now    <= served;
      result.status        <= status;
    end
  end

endmodule

/* rtl/elevator_fifo_request_controller.sv */
// Top level of the elevator FIFO request controller.
// Joins efrc_ctrl and efrc_dpath; depends on efrc_pkg.
//
// Usage:
//   A transaction (tick, floor request or service toggle) is taken on cmd at a
//   rising edge where start is high and busy is low. busy is high for the one
//   execute cycle that follows. The result appears on result in the cycle after,
//   marked by done for exactly one cycle; the receiver cannot stall it.
//   No new transaction is taken while busy is high, set by the load/execute
//   sequence of the controller; a new start may be taken while done is high.
//   The duplicate check compares every occupied queue cell in parallel in the execute
//   cycle, and the queue is a shift line with its head in cell 0.
//   Config: wr_en/wr_index/wr_data write floor_count (index 0) and
//   underground_count (index 1); write only while idle.
//   Reset (rst, synchronous): car at floor 0, not in service, idle count 0,
//   queue empty, floor_count 10, underground_count 2.
`timescale 1ns / 1ps

module elevator_fifo_request_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  efrc_pkg::cmd_t                   cmd,
  output logic                             done,
  output efrc_pkg::result_t                result,
  input  logic                             wr_en,
  input  logic [efrc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [efrc_pkg::CFG_DATA_W-1:0]  wr_data
);
  import efrc_pkg::*;

  dp_ctrl_t dp_ctrl;

  efrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .dp_ctrl (dp_ctrl)
  );

  efrc_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .dp_ctrl  (dp_ctrl),
    .cmd      (cmd),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .result   (result)
  );

endmodule
